>>> sv/cts_pkg.sv
// Shared constants and types for the column to span converter.
package cts_pkg;

  localparam int unsigned HEIGHT = 64;
  localparam int unsigned WIDTH  = 256;

  localparam int unsigned ROW_W  = $clog2(HEIGHT);
  localparam int unsigned TOP_W  = ROW_W + 1;
  localparam int unsigned XIN_W  = 9;
  localparam int unsigned XS_W   = 8;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [TOP_W-1:0] top_t;
  typedef logic [XIN_W-1:0] xin_t;
  typedef logic [XS_W-1:0]  xcol_t;

  typedef struct packed {
    logic  valid;
    row_t  row;
    xcol_t x_end;
    logic  last;
  } rd_req_t;

  typedef struct packed {
    logic  en;
    row_t  addr;
    xcol_t data;
  } mem_wr_t;

endpackage

>>> sv/cts_if.sv
// Handshake channels for columns in and spans out.
interface column_if;
  import cts_pkg::*;
  logic valid;
  logic ready;
  xin_t column_x;
  top_t column_top;
  row_t column_bottom;
  logic plane_start;

  modport source (output valid, column_x, column_top, column_bottom, plane_start,
                  input ready);
  modport sink (input valid, column_x, column_top, column_bottom, plane_start,
                output ready);
endinterface

interface span_if;
  import cts_pkg::*;
  logic  valid;
  logic  ready;
  row_t  span_row;
  xcol_t span_x_begin;
  xcol_t span_x_end;
  logic  last_of_run;

  modport source (output valid, span_row, span_x_begin, span_x_end, last_of_run,
                  input ready);
  modport sink (input valid, span_row, span_x_begin, span_x_end, last_of_run,
                output ready);
endinterface

>>> sv/column_to_span_converter.sv
// Top level: column to span converter with span output register.
//
//   port     | dir | payload
//   columns  | in  | column_x, column_top, column_bottom, plane_start
//   spans    | out | span_row, span_x_begin, span_x_end, last_of_run
//
// Each column first closes the rows it leaves, paced by the start-column memory read
// and the output register, then records each newly covered row.
// A column is taken only while the sequencer is idle; the last span may still wait.
// rst clears the sequencer, the stored extent and the output valid; the start
// column memory is not cleared. A stalled span output holds further closes.
module column_to_span_converter
  import cts_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  column_if.sink  columns,
  span_if.source  spans
);

  rd_req_t rd;
  logic    rd_en;
  row_t    rd_addr;
  mem_wr_t wr;
  xcol_t   rd_data;
  logic    out_free;

  assign out_free = !spans.valid || spans.ready;

  cts_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .columns  (columns),
    .out_free (out_free),
    .rd       (rd),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr       (wr)
  );

  cts_begin_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      spans.valid <= 1'b0;
    end else begin
      if (rd.valid) begin
        spans.valid <= 1'b1;
      end else if (spans.ready) begin
        spans.valid <= 1'b0;
      end
    end
    if (rd.valid) begin
      spans.span_row     <= rd.row;
      spans.span_x_begin <= rd_data;
      spans.span_x_end   <= rd.x_end;
      spans.last_of_run  <= rd.last;
    end
  end

endmodule

>>> sv/cts_begin_mem.sv
// Per-row span start column memory, one write and one registered read port.
module cts_begin_mem
  import cts_pkg::*;
(
  input  logic    clk,
  input  mem_wr_t wr,
  input  logic    rd_en,
  input  row_t    rd_addr,
  output xcol_t   rd_data
);

  xcol_t mem [HEIGHT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/cts_seq.sv
// Row sequencer: closes left rows through memory reads, then records opened rows.
module cts_seq
  import cts_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  column_if.sink  columns,
  input  logic    out_free,
  output rd_req_t rd,
  output logic    rd_en,
  output row_t    rd_addr,
  output mem_wr_t wr
);

  typedef enum logic [1:0] {S_IDLE, S_CLOSE, S_OPEN} state_t;

  state_t state;
  top_t   t1;
  row_t   b1;
  top_t   t2;
  row_t   b2;
  xcol_t  x;
  top_t   prev_top;
  row_t   prev_bottom;

  logic   closing;
  top_t   t2_in;
  row_t   b2_in;
  logic   accept;
  logic   top_cond;
  logic   bot_cond;
  logic   more;
  top_t   t1_inc;
  row_t   b1_dec;
  logic   issue;
  logic   otop_cond;
  logic   obot_cond;
  xcol_t  x_end;

  assign columns.ready = (state == S_IDLE);
  assign accept        = columns.valid && columns.ready;

  always_comb begin
    closing = int'(columns.column_x) >= int'(WIDTH);
    if (closing || int'(columns.column_top) > int'(HEIGHT)) begin
      t2_in = TOP_W'(HEIGHT);
    end else begin
      t2_in = columns.column_top;
    end
    if (closing) begin
      b2_in = '0;
    end else if (int'(columns.column_bottom) > int'(HEIGHT) - 1) begin
      b2_in = ROW_W'(HEIGHT - 1);
    end else begin
      b2_in = columns.column_bottom;
    end
  end

  always_comb begin
    t1_inc   = t1 + TOP_W'(1);
    b1_dec   = b1 - ROW_W'(1);
    top_cond = (t1 < t2) && (t1 <= {1'b0, b1});
    bot_cond = (b1 > b2) && ({1'b0, b1} >= t1);
    if (top_cond) begin
      more = ((t1_inc < t2) && (t1_inc <= {1'b0, b1})) ||
             ((b1 > b2) && ({1'b0, b1} >= t1_inc));
    end else begin
      more = (b1_dec > b2) && ({1'b0, b1_dec} >= t1);
    end
    issue     = (state == S_CLOSE) && (top_cond || bot_cond) && !rd.valid && out_free;
    rd_en     = issue;
    rd_addr   = top_cond ? t1[ROW_W-1:0] : b1;
    otop_cond = (t2 < t1) && (t2 <= {1'b0, b2});
    obot_cond = (b2 > b1) && ({1'b0, b2} >= t2);
    x_end     = x - XS_W'(1);
    wr.en     = (state == S_OPEN) && (otop_cond || obot_cond);
    wr.addr   = otop_cond ? t2[ROW_W-1:0] : b2;
    wr.data   = x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rd.valid    <= 1'b0;
      prev_top    <= TOP_W'(HEIGHT);
      prev_bottom <= '0;
    end else begin
      rd.valid <= issue;
      if (issue) begin
        rd.row   <= rd_addr;
        rd.x_end <= x_end;
        rd.last  <= !more;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (columns.plane_start) begin
              t1 <= TOP_W'(HEIGHT);
              b1 <= '0;
            end else begin
              t1 <= prev_top;
              b1 <= prev_bottom;
            end
            t2          <= t2_in;
            b2          <= b2_in;
            x           <= columns.column_x[XS_W-1:0];
            prev_top    <= t2_in;
            prev_bottom <= b2_in;
            state       <= S_CLOSE;
          end
        end
        S_CLOSE: begin
          if (!(top_cond || bot_cond)) begin
            state <= S_OPEN;
          end else if (issue) begin
            if (top_cond) begin
              t1 <= t1_inc;
            end else begin
              b1 <= b1_dec;
            end
            if (!more) begin
              state <= S_OPEN;
            end
          end
        end
        S_OPEN: begin
          if (otop_cond) begin
            t2 <= t2 + TOP_W'(1);
          end else if (obot_cond) begin
            b2 <= b2 - ROW_W'(1);
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the column to span converter: directed and random planes, predicted spans.
module testbench;
  import cts_pkg::*;

  typedef struct {
    xin_t x;
    top_t top;
    row_t bottom;
    logic start;
    bit   drain;
  } column_item_t;

  typedef struct {
    row_t  row;
    xcol_t x_begin;
    xcol_t x_end;
    logic  last;
  } span_item_t;

  logic clk;
  logic rst;

  column_if columns();
  span_if   spans();

  column_to_span_converter dut (
    .clk     (clk),
    .rst     (rst),
    .columns (columns),
    .spans   (spans)
  );

  column_item_t pending_columns[$];
  span_item_t   expected_spans[$];
  xcol_t        row_begin_col[HEIGHT];
  int           extent_top;
  int           extent_bottom;
  int           errors;
  int           col_gap_left;
  int           span_stall_left;

  function automatic span_item_t close_row(int row, xin_t x);
    span_item_t s;
    s.row     = row_t'(row);
    s.x_begin = row_begin_col[row];
    s.x_end   = xcol_t'(x - 9'd1);
    s.last    = 1'b0;
    return s;
  endfunction

  task automatic predict_spans(input xin_t x, input top_t top_in, input row_t bottom_in,
                               input logic start);
    int t1, b1, t2, b2, nt, nb;
    span_item_t run[$];
    t2 = (top_in > HEIGHT) ? HEIGHT : int'(top_in);
    b2 = int'(bottom_in);
    if (x >= WIDTH) begin
      t2 = HEIGHT;
      b2 = 0;
    end
    if (start) begin
      extent_top    = HEIGHT;
      extent_bottom = 0;
    end
    t1 = extent_top;
    b1 = extent_bottom;
    nt = t2;
    nb = b2;
    while (t1 < t2 && t1 <= b1) begin
      run = {run, close_row(t1, x)};
      t1++;
    end
    while (b1 > b2 && b1 >= t1) begin
      run = {run, close_row(b1, x)};
      b1--;
    end
    while (t2 < t1 && t2 <= b2) begin
      row_begin_col[t2] = x[XS_W-1:0];
      t2++;
    end
    while (b2 > b1 && b2 >= t2) begin
      row_begin_col[b2] = x[XS_W-1:0];
      b2--;
    end
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    expected_spans = {expected_spans, run};
    extent_top    = nt;
    extent_bottom = nb;
  endtask

  function automatic void add_column(int x, int top, int bottom, bit start);
    column_item_t c;
    c.x      = xin_t'(x);
    c.top    = top_t'(top);
    c.bottom = row_t'(bottom);
    c.start  = start;
    c.drain  = (pending_columns.size() % 120 == 119);
    pending_columns = {pending_columns, c};
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin : drive_columns
    logic next_valid;
    column_item_t c;
    if (rst) begin
      columns.valid <= 1'b0;
      col_gap_left = 0;
    end else begin
      if (columns.valid && columns.ready)
        predict_spans(columns.column_x, columns.column_top, columns.column_bottom,
                      columns.plane_start);
      if (!columns.valid || columns.ready) begin
        next_valid = 1'b0;
        if (col_gap_left > 0) begin
          col_gap_left--;
        end else if (pending_columns.size() > 0 &&
                     !(pending_columns[0].drain && expected_spans.size() != 0)) begin
          c = pending_columns.pop_front();
          columns.column_x      <= c.x;
          columns.column_top    <= c.top;
          columns.column_bottom <= c.bottom;
          columns.plane_start   <= c.start;
          next_valid = 1'b1;
          if (pending_columns.size() > 40 && $urandom_range(0, 3) == 0)
            col_gap_left = $urandom_range(1, 9);
        end
        columns.valid <= next_valid;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch_spans
    span_item_t got;
    span_item_t want;
    if (rst) begin
      spans.ready <= 1'b0;
      span_stall_left = 0;
    end else begin
      if (spans.valid && spans.ready) begin
        got.row     = spans.span_row;
        got.x_begin = spans.span_x_begin;
        got.x_end   = spans.span_x_end;
        got.last    = spans.last_of_run;
        if (expected_spans.size() == 0) begin
          errors++;
          $display("%0t unexpected span: row %0d begin %0d end %0d last %0b", $time,
                   got.row, got.x_begin, got.x_end, got.last);
        end else begin
          want = expected_spans.pop_front();
          if (got.row !== want.row || got.x_begin !== want.x_begin ||
              got.x_end !== want.x_end || got.last !== want.last) begin
            errors++;
            $display("%0t span mismatch: expected row %0d begin %0d end %0d last %0b,",
                     $time, want.row, want.x_begin, want.x_end, want.last,
                     " got row %0d begin %0d end %0d last %0b",
                     got.row, got.x_begin, got.x_end, got.last);
          end
        end
      end
      if (span_stall_left > 0) begin
        span_stall_left--;
        spans.ready <= 1'b0;
      end else begin
        spans.ready <= 1'b1;
        if (pending_columns.size() > 40 && $urandom_range(0, 9) == 0)
          span_stall_left = $urandom_range(1, 9);
      end
    end
  end

  initial begin
    int len, x, top, bottom;
    bit start;
    columns.valid         = 1'b0;
    columns.column_x      = '0;
    columns.column_top    = '0;
    columns.column_bottom = '0;
    columns.plane_start   = 1'b0;
    spans.ready           = 1'b0;
    errors        = 0;
    extent_top    = HEIGHT;
    extent_bottom = 0;
    foreach (row_begin_col[i]) row_begin_col[i] = '0;
    rst = 1'b1;

    add_column(0, 0, 63, 1);
    add_column(1, 127, 0, 0);
    add_column(5, 10, 12, 1);
    add_column(0, 11, 11, 0);
    add_column(256, 0, 63, 0);
    add_column(200, 0, 63, 1);
    add_column(201, 3, 60, 0);
    add_column(202, 5, 5, 0);
    add_column(203, 0, 63, 0);
    add_column(210, 0, 63, 1);
    add_column(255, 40, 20, 0);
    add_column(100, 20, 30, 1);
    add_column(101, 64, 63, 0);
    add_column(50, 63, 63, 1);
    add_column(51, 0, 0, 0);
    add_column(52, 0, 0, 0);
    add_column(511, 0, 0, 0);
    add_column(30, 30, 33, 1);
    add_column(31, 20, 40, 0);
    add_column(32, 35, 36, 0);
    add_column(400, 96, 45, 0);

    while (pending_columns.size() < 520) begin
      if ($urandom_range(0, 99) < 12) begin
        add_column($urandom_range(0, 511), $urandom_range(0, 127), $urandom_range(0, 63),
                   $urandom_range(0, 1));
      end else begin
        len    = $urandom_range(1, 16);
        x      = $urandom_range(0, 255);
        top    = $urandom_range(0, 63);
        bottom = $urandom_range(top, 63);
        start  = ($urandom_range(0, 5) != 0);
        for (int k = 0; k < len && x < WIDTH; k++) begin
          add_column(x, top, bottom, start && k == 0);
          x++;
          if ($urandom_range(0, 7) == 0) begin
            top    = $urandom_range(0, 63);
            bottom = $urandom_range(0, 63);
          end else begin
            top    = top + $urandom_range(0, 4) - 2;
            bottom = bottom + $urandom_range(0, 4) - 2;
          end
          top    = (top < 0) ? 0 : (top > 63) ? 63 : top;
          bottom = (bottom < 0) ? 0 : (bottom > 63) ? 63 : bottom;
        end
        case ($urandom_range(0, 5))
          0: ;
          1, 2: add_column(x < WIDTH ? x : 0, $urandom_range(64, 127), $urandom_range(0, 63), 0);
          default: add_column($urandom_range(WIDTH, 511), $urandom_range(0, 127),
                              $urandom_range(0, 63), 0);
        endcase
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (pending_columns.size() > 0 || columns.valid) @(posedge clk);
    while (expected_spans.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_spans.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #15000000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> filelist.f
sv/cts_pkg.sv
sv/cts_if.sv
sv/cts_begin_mem.sv
sv/cts_seq.sv
sv/column_to_span_converter.sv
tb/sv/testbench.sv
